@@ rtl/core/rvx_pkg.sv @@
// ----------------------------------------------------------------------------
// rvx_pkg
// shared types and constants of the rv32i execute unit
// ----------------------------------------------------------------------------
package rvx_pkg;

  localparam int unsigned MEM_WORDS_DEF = 1024;
  localparam int unsigned XLEN          = 32;
  localparam int unsigned RIDX_W        = 5;

  typedef enum logic [4:0] {
    CMD_ADD   = 5'd0,
    CMD_SUB   = 5'd1,
    CMD_XOR   = 5'd2,
    CMD_OR    = 5'd3,
    CMD_AND   = 5'd4,
    CMD_SLL   = 5'd5,
    CMD_SLT   = 5'd6,
    CMD_SRL   = 5'd7,
    CMD_SRA   = 5'd8,
    CMD_SLTI  = 5'd9,
    CMD_ADDI  = 5'd10,
    CMD_ANDI  = 5'd11,
    CMD_XORI  = 5'd12,
    CMD_ORI   = 5'd13,
    CMD_SLLI  = 5'd14,
    CMD_SRLI  = 5'd15,
    CMD_SRAI  = 5'd16,
    CMD_LW    = 5'd17,
    CMD_SW    = 5'd18,
    CMD_BEQ   = 5'd19,
    CMD_BNE   = 5'd20,
    CMD_BLT   = 5'd21,
    CMD_BGE   = 5'd22,
    CMD_LUI   = 5'd23,
    CMD_AUIPC = 5'd24,
    CMD_JAL   = 5'd25,
    CMD_JALR  = 5'd26
  } cmd_t;

  localparam logic [XLEN-1:0] PC_STEP  = 32'd4;
  localparam logic [XLEN-1:0] ALIGN_J  = ~32'd1;

  typedef struct packed {
    logic [4:0]             cmd;
    logic [RIDX_W-1:0]      dest_reg;
    logic [RIDX_W-1:0]      src1_reg;
    logic [RIDX_W-1:0]      src2_reg;
    logic signed [XLEN-1:0] immediate;
  } exec_in_t;

  typedef struct packed {
    logic [XLEN-1:0]        next_pc;
    logic                   reg_written;
    logic [RIDX_W-1:0]      written_index;
    logic signed [XLEN-1:0] written_value;
    logic                   mem_written;
    logic [XLEN-1:0]        mem_address;
  } exec_out_t;

  // execute result handed from the alu to the pipeline control
  typedef struct packed {
    logic [XLEN-1:0] next_pc;
    logic            reg_wr;
    logic [XLEN-1:0] value;
    logic            mem_wr;
    logic            mem_rd;
    logic [XLEN-1:0] mem_addr;
  } alu_res_t;

  // register file write port
  typedef struct packed {
    logic              en;
    logic [RIDX_W-1:0] idx;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

endpackage

@@ rtl/core/rvx_regfile.sv @@
// ----------------------------------------------------------------------------
// rvx_regfile
// 32 x 32 register file, one write and two registered read ports, with
// valid bits for reset-to-zero and bypass of a same-edge write
// ----------------------------------------------------------------------------
module rvx_regfile
  import rvx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  rf_wr_t            wr,
  input  logic              re,
  input  logic [RIDX_W-1:0] raddr_a,
  input  logic [RIDX_W-1:0] raddr_b,
  output logic [XLEN-1:0]   rdata_a,
  output logic [XLEN-1:0]   rdata_b
);

  localparam int unsigned DEPTH = 2 ** RIDX_W;

  logic [XLEN-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  logic [XLEN-1:0] q_a;
  logic [XLEN-1:0] q_b;
  logic            ok_a;
  logic            ok_b;
  logic            byp_a;
  logic            byp_b;
  logic [XLEN-1:0] byp_data;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.idx] <= 1'b1;
    end
  end

  // read before write, so a write on the read edge is caught by the bypass
  always_ff @(posedge clk) begin
    if (re) begin
      q_a      <= mem[raddr_a];
      q_b      <= mem[raddr_b];
      ok_a     <= valid[raddr_a];
      ok_b     <= valid[raddr_b];
      byp_a    <= wr.en && (wr.idx == raddr_a);
      byp_b    <= wr.en && (wr.idx == raddr_b);
      byp_data <= wr.data;
    end
  end

  assign rdata_a = byp_a ? byp_data : (ok_a ? q_a : '0);
  assign rdata_b = byp_b ? byp_data : (ok_b ? q_b : '0);

endmodule

@@ rtl/core/rvx_dmem.sv @@
// ----------------------------------------------------------------------------
// rvx_dmem
// single-port word data memory with registered read data
// ----------------------------------------------------------------------------
module rvx_dmem
  import rvx_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF,
  localparam int unsigned AW       = $clog2(MEM_WORDS)
) (
  input  logic            clk,
  input  logic            en,
  input  logic            we,
  input  logic [AW-1:0]   addr,
  input  logic [XLEN-1:0] wdata,
  output logic [XLEN-1:0] rdata
);

  logic [XLEN-1:0] mem [MEM_WORDS];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ rtl/core/rvx_alu.sv @@
// ----------------------------------------------------------------------------
// rvx_alu
// execute logic: alu result, branch and jump target, memory address
// ----------------------------------------------------------------------------
module rvx_alu
  import rvx_pkg::*;
(
  input  exec_in_t        instr,
  input  logic [XLEN-1:0] a,
  input  logic [XLEN-1:0] b,
  input  logic [XLEN-1:0] pc,
  output alu_res_t        res
);

  logic [XLEN-1:0] imm;
  logic [XLEN-1:0] pc_inc;
  logic [XLEN-1:0] addr_sum;
  logic            lt_ab;
  logic            wr;

  assign imm      = instr.immediate;
  assign pc_inc   = pc + PC_STEP;
  assign addr_sum = a + imm;
  assign lt_ab    = $signed(a) < $signed(b);

  always_comb begin
    res          = '0;
    res.next_pc  = pc;
    wr           = 1'b1;
    case (cmd_t'(instr.cmd))
      CMD_ADD:   res.value = a + b;
      CMD_SUB:   res.value = a - b;
      CMD_XOR:   res.value = a ^ b;
      CMD_OR:    res.value = a | b;
      CMD_AND:   res.value = a & b;
      CMD_SLL:   res.value = a << b[4:0];
      CMD_SLT:   res.value = {31'd0, lt_ab};
      CMD_SRL:   res.value = a >> b[4:0];
      CMD_SRA:   res.value = 32'($signed(a) >>> b[4:0]);
      CMD_SLTI:  res.value = {31'd0, ($signed(a) < $signed(imm))};
      CMD_ADDI:  res.value = addr_sum;
      CMD_ANDI:  res.value = a & imm;
      CMD_XORI:  res.value = a ^ imm;
      CMD_ORI:   res.value = a | imm;
      CMD_SLLI:  res.value = a << imm[4:0];
      CMD_SRLI:  res.value = a >> imm[4:0];
      CMD_SRAI:  res.value = 32'($signed(a) >>> imm[4:0]);
      CMD_LW: begin
        res.mem_rd   = 1'b1;
        res.mem_addr = addr_sum;
      end
      CMD_SW: begin
        res.mem_wr   = 1'b1;
        res.mem_addr = addr_sum;
        res.value    = b;
        wr           = 1'b0;
      end
      CMD_BEQ: begin
        res.next_pc = pc + ((a == b) ? imm : PC_STEP);
        wr          = 1'b0;
      end
      CMD_BNE: begin
        res.next_pc = pc + ((a != b) ? imm : PC_STEP);
        wr          = 1'b0;
      end
      CMD_BLT: begin
        res.next_pc = pc + (lt_ab ? imm : PC_STEP);
        wr          = 1'b0;
      end
      CMD_BGE: begin
        res.next_pc = pc + (!lt_ab ? imm : PC_STEP);
        wr          = 1'b0;
      end
      CMD_LUI:   res.value = imm;
      CMD_AUIPC: res.value = pc + imm;
      CMD_JAL: begin
        res.value   = pc_inc;
        res.next_pc = pc + imm;
      end
      CMD_JALR: begin
        res.value   = pc_inc;
        res.next_pc = addr_sum & ALIGN_J;
      end
      default:   wr = 1'b0;
    endcase
    // x0 is never written
    res.reg_wr = wr && (instr.dest_reg != '0);
  end

endmodule

@@ rtl/core/rv32i_execute_unit.sv @@
// ----------------------------------------------------------------------------
// rv32i_execute_unit
// result path: execute stage, output register; lw via load stage (data memory read)
// one instruction a cycle while result_ready is high; a lw in execute holds the input
// reset: pc and register file read as zero, pipeline empty; data memory is not cleared
// MEM_WORDS must be a power of two; the word index is address bits above bit 1
// ----------------------------------------------------------------------------
module rv32i_execute_unit
  import rvx_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      instr_valid,
  output logic      instr_ready,
  input  exec_in_t  instr,
  output logic      result_valid,
  input  logic      result_ready,
  output exec_out_t result
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  // execute stage: instruction plus register file read data
  logic            e_valid;
  exec_in_t        e_instr;
  logic [XLEN-1:0] pc;
  logic [XLEN-1:0] rs_a;
  logic [XLEN-1:0] rs_b;
  alu_res_t        res;

  // load stage: waits for the data memory read
  logic              m_valid;
  logic              m_wr;
  logic [RIDX_W-1:0] m_idx;
  logic [XLEN-1:0]   m_next_pc;
  logic [XLEN-1:0]   m_addr;
  logic [XLEN-1:0]   dmem_q;

  // output register
  logic      o_valid;
  exec_out_t o_data;

  logic   accept;
  logic   out_free;
  logic   m_done;
  logic   e_done;
  logic   e_to_out;
  logic   dmem_en;
  rf_wr_t rf_wr;

  assign out_free = !o_valid || result_ready;
  assign m_done   = m_valid && out_free;

  // a load moves on to the load stage, anything else needs the output
  // register and no older load in front of it
  always_comb begin
    if (!e_valid) begin
      e_done = 1'b0;
    end else if (res.mem_rd) begin
      e_done = !m_valid || m_done;
    end else begin
      e_done = !m_valid && out_free;
    end
  end

  assign e_to_out = e_done && !res.mem_rd;

  // a new transaction enters only when no register write can follow its
  // operand read except on the same edge, where the bypass catches it
  assign instr_ready = (!e_valid || e_to_out) && (!m_valid || m_done);
  assign accept      = instr_valid && instr_ready;

  // register file write: completing load first, else the execute stage
  always_comb begin
    rf_wr = '0;
    if (m_done && m_wr) begin
      rf_wr.en   = 1'b1;
      rf_wr.idx  = m_idx;
      rf_wr.data = dmem_q;
    end else if (e_to_out && res.reg_wr) begin
      rf_wr.en   = 1'b1;
      rf_wr.idx  = e_instr.dest_reg;
      rf_wr.data = res.value;
    end
  end

  rvx_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .wr      (rf_wr),
    .re      (accept),
    .raddr_a (instr.src1_reg),
    .raddr_b (instr.src2_reg),
    .rdata_a (rs_a),
    .rdata_b (rs_b)
  );

  rvx_alu u_alu (
    .instr (e_instr),
    .a     (rs_a),
    .b     (rs_b),
    .pc    (pc),
    .res   (res)
  );

  // stores write and loads read as the instruction leaves execute
  assign dmem_en = e_done && (res.mem_rd || res.mem_wr);

  rvx_dmem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dmem (
    .clk   (clk),
    .en    (dmem_en),
    .we    (res.mem_wr),
    .addr  (res.mem_addr[AW+1:2]),
    .wdata (res.value),
    .rdata (dmem_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      m_valid <= 1'b0;
      o_valid <= 1'b0;
      pc      <= '0;
    end else begin
      if (accept) begin
        e_valid <= 1'b1;
      end else if (e_done) begin
        e_valid <= 1'b0;
      end
      if (e_done && res.mem_rd) begin
        m_valid <= 1'b1;
      end else if (m_done) begin
        m_valid <= 1'b0;
      end
      if (out_free) begin
        o_valid <= m_done || e_to_out;
      end
      if (e_done) begin
        pc <= res.next_pc;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      e_instr <= instr;
    end
    if (e_done && res.mem_rd) begin
      m_wr      <= res.reg_wr;
      m_idx     <= e_instr.dest_reg;
      m_next_pc <= res.next_pc;
      m_addr    <= res.mem_addr;
    end
    if (m_done) begin
      o_data.next_pc       <= m_next_pc;
      o_data.reg_written   <= m_wr;
      o_data.written_index <= m_wr ? m_idx : '0;
      o_data.written_value <= m_wr ? dmem_q : '0;
      o_data.mem_written   <= 1'b0;
      o_data.mem_address   <= m_addr;
    end else if (e_to_out) begin
      o_data.next_pc       <= res.next_pc;
      o_data.reg_written   <= res.reg_wr;
      o_data.written_index <= res.reg_wr ? e_instr.dest_reg : '0;
      o_data.written_value <= res.reg_wr ? res.value : '0;
      o_data.mem_written   <= res.mem_wr;
      o_data.mem_address   <= res.mem_addr;
    end
  end

  assign result_valid = o_valid;
  assign result       = o_data;

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// rv32i_execute_unit testbench
// runs pre-decoded instructions through the execute unit and checks every
// result transaction against an in-bench prediction of the register file,
// program counter and data memory; directed corner cases first, then a long
// random stream biased towards loads, stores and branches
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rvx_pkg::*;

  localparam int          IDX_W          = $clog2(MEM_WORDS_DEF);
  localparam int          CYCLE_LIMIT    = 400000;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          RANDOM_ITEMS   = 1250;
  // operation codes the unit treats as no-ops
  localparam logic [4:0]  CMD_RSVD_FIRST = 5'd27;
  localparam logic [4:0]  CMD_RSVD_LAST  = 5'd31;

  logic      clk;
  logic      rst          = 1'b1;
  logic      instr_valid  = 1'b0;
  logic      instr_ready;
  exec_in_t  instr        = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  exec_out_t result;

  // predicted architectural state
  logic [XLEN-1:0]  regs [32] = '{default: '0};
  logic [XLEN-1:0]  prog_ctr  = '0;
  logic [XLEN-1:0]  dmem [MEM_WORDS_DEF];
  bit               word_valid [MEM_WORDS_DEF];
  logic [IDX_W-1:0] stored_idx [$];

  // outcomes still owed by the unit, oldest first
  exec_out_t outcome_q [$];

  int        mismatches  = 0;
  int        cycle_count = 0;
  bit        no_idle     = 1'b0;
  exec_out_t owed;

  rv32i_execute_unit dut (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_ready  (instr_ready),
    .instr        (instr),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t ns: timeout with %0d results outstanding", $time, outcome_q.size());
    $display("rv32i_execute_unit regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // prediction: executes one accepted instruction on the local state and
  // queues the outcome the unit has to return for it
  // --------------------------------------------------------------------------
  task automatic execute_instr(input exec_in_t ins);
    logic [XLEN-1:0]  a, b, imm, val, nxt, addr;
    logic [IDX_W-1:0] widx;
    logic             wr, memw;
    exec_out_t        res;
    a    = regs[ins.src1_reg];   // x0 is never written, so it reads as zero
    b    = regs[ins.src2_reg];
    imm  = ins.immediate;
    nxt  = prog_ctr;
    val  = '0;
    wr   = 1'b1;
    memw = 1'b0;
    addr = '0;
    case (ins.cmd)
      CMD_ADD:   val = a + b;
      CMD_SUB:   val = a - b;
      CMD_XOR:   val = a ^ b;
      CMD_OR:    val = a | b;
      CMD_AND:   val = a & b;
      CMD_SLL:   val = a << b[4:0];
      CMD_SLT:   val = {31'd0, $signed(a) < $signed(b)};
      CMD_SRL:   val = a >> b[4:0];
      CMD_SRA:   val = $signed(a) >>> b[4:0];
      CMD_SLTI:  val = {31'd0, $signed(a) < $signed(imm)};
      CMD_ADDI:  val = a + imm;
      CMD_ANDI:  val = a & imm;
      CMD_XORI:  val = a ^ imm;
      CMD_ORI:   val = a | imm;
      CMD_SLLI:  val = a << imm[4:0];
      CMD_SRLI:  val = a >> imm[4:0];
      CMD_SRAI:  val = $signed(a) >>> imm[4:0];
      CMD_LW: begin
        addr = a + imm;
        val  = dmem[addr[IDX_W+1:2]];
      end
      CMD_SW: begin
        addr = a + imm;
        widx = addr[IDX_W+1:2];
        dmem[widx] = b;
        if (!word_valid[widx]) begin
          word_valid[widx] = 1'b1;
          stored_idx.push_back(widx);
        end
        memw = 1'b1;
        wr   = 1'b0;
      end
      CMD_BEQ: begin
        nxt = prog_ctr + ((a == b) ? imm : PC_STEP);
        wr  = 1'b0;
      end
      CMD_BNE: begin
        nxt = prog_ctr + ((a != b) ? imm : PC_STEP);
        wr  = 1'b0;
      end
      CMD_BLT: begin
        nxt = prog_ctr + (($signed(a) < $signed(b)) ? imm : PC_STEP);
        wr  = 1'b0;
      end
      CMD_BGE: begin
        nxt = prog_ctr + (($signed(a) >= $signed(b)) ? imm : PC_STEP);
        wr  = 1'b0;
      end
      CMD_LUI:   val = imm;
      CMD_AUIPC: val = prog_ctr + imm;
      CMD_JAL: begin
        val = prog_ctr + PC_STEP;
        nxt = prog_ctr + imm;
      end
      CMD_JALR: begin
        // target from the old base value, link written afterwards
        val = prog_ctr + PC_STEP;
        nxt = (a + imm) & ALIGN_J;
      end
      default:   wr = 1'b0;
    endcase
    if (ins.dest_reg == '0) wr = 1'b0;
    if (wr) regs[ins.dest_reg] = val;
    prog_ctr = nxt;

    res.next_pc       = nxt;
    res.reg_written   = wr;
    res.written_index = wr ? ins.dest_reg : '0;
    res.written_value = wr ? val : '0;
    res.mem_written   = memw;
    res.mem_address   = addr;
    outcome_q.push_back(res);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  // one instruction transaction; an occasional idle gap before it, valid is
  // held with a stable payload until the unit takes it
  task automatic send_op(input logic [4:0] cmd, input logic [4:0] rd,
                         input logic [4:0] rs1, input logic [4:0] rs2,
                         input logic [XLEN-1:0] imm);
    exec_in_t item;
    item.cmd       = cmd;
    item.dest_reg  = rd;
    item.src1_reg  = rs1;
    item.src2_reg  = rs2;
    item.immediate = imm;
    if (!no_idle && $urandom_range(99) < 4) begin
      instr_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 35);
    end
    instr_valid <= 1'b1;
    instr       <= item;
    do @(posedge clk); while (!instr_ready);
    execute_instr(item);
  endtask

  // immediates: full range, decoder-sized, extremes and word offsets
  function automatic logic [XLEN-1:0] pick_imm();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(4095) - 2048;
      2: begin
        case ($urandom_range(5))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'hffff_ffff;
          3:       return 32'h0000_0000;
          4:       return PC_STEP;
          default: return -PC_STEP;
        endcase
      end
      default: return ($urandom_range(255) - 128) << 2;
    endcase
  endfunction

  // immediate that makes base + imm land on an already stored word,
  // with random upper and byte-offset bits to exercise wrap-around
  function automatic logic [XLEN-1:0] imm_to_stored(input logic [4:0] base);
    logic [XLEN-1:0] addr;
    addr = $urandom();
    addr[IDX_W+1:2] = stored_idx[$urandom_range(stored_idx.size() - 1)];
    return addr - regs[base];
  endfunction

  // corner values built up in x1..x11, with overflow and x0 destination
  task automatic test_alu_extremes();
    send_op(CMD_LUI,  5'd1,  5'd0, 5'd0, 32'h8000_0000);
    send_op(CMD_ADDI, 5'd2,  5'd0, 5'd0, 32'h7fff_ffff);
    send_op(CMD_XORI, 5'd3,  5'd0, 5'd0, 32'hffff_ffff);
    send_op(CMD_ADD,  5'd4,  5'd2, 5'd2, 32'h0);           // wraps
    send_op(CMD_SUB,  5'd5,  5'd1, 5'd2, 32'h0);           // wraps to 1
    send_op(CMD_XOR,  5'd6,  5'd1, 5'd3, 32'h0);
    send_op(CMD_OR,   5'd0,  5'd1, 5'd2, 32'h0);           // x0 stays zero
    send_op(CMD_AND,  5'd8,  5'd3, 5'd2, 32'h0);
    send_op(CMD_SLT,  5'd9,  5'd1, 5'd2, 32'h0);
    send_op(CMD_SLTI, 5'd10, 5'd2, 5'd0, 32'h8000_0000);
    send_op(CMD_ANDI, 5'd11, 5'd3, 5'd0, 32'h8000_0000);
    send_op(CMD_ORI,  5'd7,  5'd0, 5'd0, 32'h7fff_ffff);
  endtask

  // only the low five bits of any shift amount count
  task automatic test_shifts();
    send_op(CMD_SLL,  5'd12, 5'd3, 5'd2, 32'h0);
    send_op(CMD_SRL,  5'd13, 5'd1, 5'd3, 32'h0);
    send_op(CMD_SRA,  5'd14, 5'd1, 5'd3, 32'h0);
    send_op(CMD_SLLI, 5'd15, 5'd2, 5'd0, 32'hffff_ffe1);
    send_op(CMD_SRLI, 5'd16, 5'd3, 5'd0, 32'h0000_0020);
    send_op(CMD_SRAI, 5'd17, 5'd1, 5'd0, 32'h0000_0004);
  endtask

  // address wrap past the top word and misaligned byte offsets
  task automatic test_memory();
    send_op(CMD_SW, 5'd9,  5'd0, 5'd1, 32'hffff_fffc);     // top word
    send_op(CMD_SW, 5'd0,  5'd3, 5'd2, 32'h0000_0005);     // wraps to byte 4
    send_op(CMD_LW, 5'd18, 5'd0, 5'd0, 32'h0000_0ffc);
    send_op(CMD_LW, 5'd19, 5'd1, 5'd0, 32'h0000_0007);
  endtask

  // taken and not-taken branches, links and the jalr target rules
  task automatic test_control_flow();
    send_op(CMD_BEQ,   5'd0,  5'd1, 5'd1, 32'hffff_fff8);
    send_op(CMD_BNE,   5'd0,  5'd1, 5'd1, 32'h0000_0010);
    send_op(CMD_BLT,   5'd0,  5'd1, 5'd2, 32'h0000_0010);
    send_op(CMD_BGE,   5'd0,  5'd1, 5'd2, 32'h0000_0010);
    send_op(CMD_AUIPC, 5'd20, 5'd0, 5'd0, 32'h1234_5000);
    send_op(CMD_JAL,   5'd21, 5'd0, 5'd0, 32'h7fff_fffe);
    send_op(CMD_JALR,  5'd5,  5'd5, 5'd0, 32'h0000_0006); // odd target, rd = rs1
  endtask

  task automatic test_unused_codes();
    send_op(CMD_RSVD_FIRST, 5'd7, 5'd1, 5'd2, 32'hffff_ffff);
    send_op(CMD_RSVD_LAST,  5'd7, 5'd3, 5'd1, 32'h8000_0000);
  endtask

  // random stream: stores, loads of stored words, branches, then anything
  task automatic test_random(input int count);
    logic [4:0]      cmd, rd, rs1, rs2;
    logic [XLEN-1:0] imm;
    int              pick;
    for (int n = 0; n < count; n++) begin
      // long stretch with both sides running flat out
      no_idle = (n >= count / 3) && (n < count / 2);
      rd   = 5'($urandom());
      rs1  = 5'($urandom());
      rs2  = ($urandom_range(3) == 0) ? rs1 : 5'($urandom());
      imm  = pick_imm();
      pick = $urandom_range(99);
      if (pick < 14) begin
        cmd = CMD_SW;
        if (stored_idx.size() != 0 && $urandom_range(1) == 0) imm = imm_to_stored(rs1);
      end else if (pick < 28 && stored_idx.size() != 0) begin
        cmd = CMD_LW;
        imm = imm_to_stored(rs1);
      end else if (pick < 42) begin
        cmd = 5'($urandom_range(CMD_BEQ, CMD_BGE));
      end else begin
        cmd = 5'($urandom_range(CMD_RSVD_LAST));
        // never read a word that was never stored
        if (cmd == CMD_LW) begin
          if (stored_idx.size() != 0) imm = imm_to_stored(rs1);
          else cmd = CMD_SW;
        end
      end
      send_op(cmd, rd, rs1, rs2, imm);
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // result side: random back-pressure and an in-order check of every
  // accepted result transaction
  // --------------------------------------------------------------------------
  function automatic void check_field(input string field, input logic [XLEN-1:0] want,
                                      input logic [XLEN-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (outcome_q.size() == 0) begin
        $display("%0t ns: result with no instruction outstanding: %p", $time, result);
        mismatches++;
      end else begin
        owed = outcome_q.pop_front();
        check_field("next_pc",       owed.next_pc,       result.next_pc);
        check_field("reg_written",   XLEN'(owed.reg_written),
                    XLEN'(result.reg_written));
        check_field("written_index", XLEN'(owed.written_index),
                    XLEN'(result.written_index));
        check_field("written_value", owed.written_value, result.written_value);
        check_field("mem_written",   XLEN'(owed.mem_written),
                    XLEN'(result.mem_written));
        check_field("mem_address",   owed.mem_address,   result.mem_address);
      end
    end
    // stall at random with a chance of about six percent
    result_ready <= no_idle || ($urandom_range(99) >= 6);
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_alu_extremes();
    test_shifts();
    test_memory();
    test_control_flow();
    test_unused_codes();
    test_random(RANDOM_ITEMS);

    instr_valid <= 1'b0;
    // drain, then allow for a stray extra result
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("rv32i_execute_unit regression: pass");
    end else begin
      $display("rv32i_execute_unit regression: fail");
    end
    $finish;
  end

endmodule
